// ===== hw/rtl/fqw_pkg.sv =====
// Shared types and codes for the queue with front-to-rear walk.
`timescale 1ns / 1ps

package fqw_pkg;

    // Width of one stored value.
    localparam int VALUE_W = 32;
    // Width of the entry count carried on every result.
    localparam int HELD_W  = 6;

    // Operation codes on the input side.
    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_SHOW = 2'd2
    } t_op;

    // Status codes on the result side.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Classified command passed from the front to the back.
    typedef enum logic [1:0] {
        CMD_ENQ,
        CMD_DEQ,
        CMD_SHOW
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

    // Back-end sequencer states.
    typedef enum logic {
        S_IDLE,
        S_DATA
    } t_state;

endpackage

// ===== hw/rtl/fifo_queue_with_walk_core.sv =====
// Top level of the queue: front command buffer feeding the execution back end.
// Enqueue and every empty or full result pass the command buffer and the result register;
// a dequeue result or a displayed entry also passes the registered store read.
// Throughput: one enqueue per cycle while the result side accepts; a dequeue or a display
// holds the back end, taking no new command, until its last entry is in the result register.
// Reset (synchronous, active low) empties the queue; stored values are not cleared.
`timescale 1ns / 1ps

module fifo_queue_with_walk_core #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [31:0] value
    input  logic [31:0] i_s_tdata,
    // [1:0] operation
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [31:0] item, [37:32] entries_held, [39:38] zero
    output logic [39:0] o_m_tdata,
    // [1:0] status
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast
);

    import fqw_pkg::*;

    t_cmd                       w_cmd;
    logic                       w_cmd_valid;
    logic                       w_cmd_pop;
    logic signed [VALUE_W-1:0]  w_item;
    logic [HELD_W-1:0]          w_held;

    // Front: accept and classify transactions.
    fqw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    // Back: carry out commands against the ring.
    fqw_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_status  (o_m_tuser),
        .o_m_item    (w_item),
        .o_m_held    (w_held),
        .o_m_tlast   (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, w_held, w_item};

endmodule

// ===== hw/rtl/fqw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fqw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/fqw_front.sv =====
// Input side: accepts transactions, classifies them and buffers commands.
`timescale 1ns / 1ps

module fqw_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic signed [fqw_pkg::VALUE_W-1:0]   i_s_tdata,
    input  logic [1:0]                           i_s_tuser,
    output logic                                 o_cmd_valid,
    input  logic                                 i_cmd_pop,
    output fqw_pkg::t_cmd                        o_cmd
);

    import fqw_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_push;
    logic       w_known;
    t_cmd       w_cmd;

    // Map the operation code onto a command; unknown codes are dropped.
    always_comb begin
        w_known     = 1'b1;
        w_cmd.value = i_s_tdata;
        case (i_s_tuser)
            OP_ENQ:  w_cmd.kind = CMD_ENQ;
            OP_DEQ:  w_cmd.kind = CMD_DEQ;
            OP_SHOW: w_cmd.kind = CMD_SHOW;
            default: begin
                w_cmd.kind = CMD_ENQ;
                w_known    = 1'b0;
            end
        endcase
    end

    assign o_s_tready  = (r_count != 2'd2);
    assign w_push      = i_s_tvalid && o_s_tready && w_known;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];

    // Pointer and fill bookkeeping of the two-entry command queue.
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ i_cmd_pop;
        n_count  = r_count + {1'b0, w_push} - {1'b0, i_cmd_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Command storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ===== hw/rtl/fqw_back.sv =====
// Execution side: ring pointers, store access and the result register.
`timescale 1ns / 1ps

module fqw_back #(
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_valid,
    output logic                                 o_cmd_pop,
    input  fqw_pkg::t_cmd                        i_cmd,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [1:0]                           o_m_status,
    output logic signed [fqw_pkg::VALUE_W-1:0]   o_m_item,
    output logic [fqw_pkg::HELD_W-1:0]           o_m_held,
    output logic                                 o_m_tlast
);

    import fqw_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state r_state, n_state;

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_occ, n_occ;
    logic [AW-1:0] r_walk, n_walk;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_held, n_held;

    logic                       r_out_valid, n_out_valid;
    logic [1:0]                 r_out_status, n_out_status;
    logic signed [VALUE_W-1:0]  r_out_item, n_out_item;
    logic [CW-1:0]              r_out_held, n_out_held;
    logic                       r_out_last, n_out_last;

    logic                       w_out_free;
    logic                       w_wr_en;
    logic                       w_rd_en;
    logic [AW-1:0]              w_rd_addr;
    logic [VALUE_W-1:0]         w_rd_data;

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid && w_out_free;
    assign w_wr_en    = o_cmd_pop && (i_cmd.kind == CMD_ENQ) && (r_occ != FULL_CNT);

    fqw_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Next state: a dequeue or a walk over held entries waits on read data.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd_pop && (i_cmd.kind != CMD_ENQ) && (r_occ != '0)) begin
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (w_out_free && (r_left == CW'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath: pointer updates, store reads and loading of the result register.
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_occ        = r_occ;
        n_walk       = r_walk;
        n_left       = r_left;
        n_held       = r_held;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_item   = r_out_item;
        n_out_held   = r_out_held;
        n_out_last   = r_out_last;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_head;
        case (r_state)
            S_IDLE: begin
                if (o_cmd_pop) begin
                    case (i_cmd.kind)
                        CMD_ENQ: begin
                            n_out_valid = 1'b1;
                            n_out_item  = '0;
                            n_out_last  = 1'b1;
                            if (r_occ == FULL_CNT) begin
                                n_out_status = ST_FULL;
                                n_out_held   = r_occ;
                            end else begin
                                n_tail       = wrap_next(r_tail);
                                n_occ        = r_occ + CW'(1);
                                n_out_status = ST_OK;
                                n_out_held   = r_occ + CW'(1);
                            end
                        end
                        CMD_DEQ, CMD_SHOW: begin
                            if (r_occ == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                                n_out_item   = '0;
                                n_out_held   = '0;
                                n_out_last   = 1'b1;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_head;
                                if (i_cmd.kind == CMD_DEQ) begin
                                    n_head = wrap_next(r_head);
                                    n_occ  = r_occ - CW'(1);
                                    n_left = CW'(1);
                                    n_held = r_occ - CW'(1);
                                end else begin
                                    n_walk = wrap_next(r_head);
                                    n_left = r_occ;
                                    n_held = r_occ;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DATA: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_item   = w_rd_data;
                    n_out_held   = r_held;
                    n_out_last   = (r_left == CW'(1));
                    if (r_left != CW'(1)) begin
                        // Fetch the following entry while this one goes out.
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_walk;
                        n_walk    = wrap_next(r_walk);
                        n_left    = r_left - CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // Walk counters and result payload.
    always_ff @(posedge i_clk) begin
        r_walk       <= n_walk;
        r_left       <= n_left;
        r_held       <= n_held;
        r_out_status <= n_out_status;
        r_out_item   <= n_out_item;
        r_out_held   <= n_out_held;
        r_out_last   <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_status = r_out_status;
    assign o_m_item   = r_out_item;
    assign o_m_held   = HELD_W'(r_out_held);
    assign o_m_tlast  = r_out_last;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the queue with front-to-rear walk.
`timescale 1ns / 1ps

module testbench;

    import fqw_pkg::*;

    localparam int          DEPTH        = 32;
    localparam int          IDLE_LIMIT   = 3000;
    localparam int          RANDOM_ITEMS = 300;
    // Operation code outside the enum; the block drops it without a result.
    localparam logic [1:0]  OP_IGNORED   = 2'd3;

    // One result as seen on the master side.
    typedef struct {
        t_status      status;
        logic [31:0]  item;
        logic [5:0]   held;
        logic         last;
    } t_result;

    // One row of the directed table.
    typedef struct {
        logic [1:0]   op;
        logic [31:0]  value;
        bit           typed;
        t_result      want;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [31:0]  i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [39:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         o_m_tlast;

    // Shadow copy of the queue contents.
    logic [31:0]  shadow_store [DEPTH];
    int unsigned  shadow_head;
    int unsigned  shadow_tail;
    int unsigned  shadow_count;

    t_result      pending_results [$];
    t_row         directed_rows [$];

    int           error_count;
    int           items_sent;
    int           counted_items;
    int           results_checked;
    int           full_results;
    int           empty_results;
    int           idle_cycles;
    bit           quiet;
    bit           draining;

    fifo_queue_with_walk_core #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result make_result(t_status status, logic [31:0] item,
                                            logic [5:0] held, logic last);
        t_result r;
        r.status = status;
        r.item   = item;
        r.held   = held;
        r.last   = last;
        return r;
    endfunction

    // Apply one accepted command to the shadow queue and queue up what it yields.
    function automatic void queue_predict(logic [1:0] op, logic [31:0] value);
        int unsigned idx;
        if (op == OP_ENQ) begin
            if (shadow_count >= DEPTH) begin
                pending_results.push_back(make_result(ST_FULL, '0, 6'(shadow_count), 1'b1));
                full_results++;
            end else begin
                shadow_store[shadow_tail] = value;
                shadow_tail  = (shadow_tail + 1) % DEPTH;
                shadow_count = shadow_count + 1;
                pending_results.push_back(make_result(ST_OK, '0, 6'(shadow_count), 1'b1));
            end
        end else if (op == OP_DEQ) begin
            if (shadow_count == 0) begin
                pending_results.push_back(make_result(ST_EMPTY, '0, 6'(0), 1'b1));
                empty_results++;
            end else begin
                idx          = shadow_head;
                shadow_head  = (shadow_head + 1) % DEPTH;
                shadow_count = shadow_count - 1;
                pending_results.push_back(make_result(ST_OK, shadow_store[idx],
                                                      6'(shadow_count), 1'b1));
            end
        end else if (op == OP_SHOW) begin
            if (shadow_count == 0) begin
                pending_results.push_back(make_result(ST_EMPTY, '0, 6'(0), 1'b1));
                empty_results++;
            end else begin
                idx = shadow_head;
                for (int k = 0; k < shadow_count; k++) begin
                    pending_results.push_back(make_result(ST_OK, shadow_store[idx],
                                                          6'(shadow_count),
                                                          k + 1 == shadow_count));
                    idx = (idx + 1) % DEPTH;
                end
            end
        end
    endfunction

    // Sender gap: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random value with a bias towards the extremes.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_row(logic [1:0] op, logic [31:0] value, bit typed,
                                    t_status status, logic [31:0] item, logic [5:0] held);
        t_row row;
        row.op    = op;
        row.value = value;
        row.typed = typed;
        row.want  = make_result(status, item, held, 1'b1);
        directed_rows.push_back(row);
    endfunction

    // Drive one slave-side transaction and predict it once it is taken.
    task automatic send_item(logic [1:0] op, logic [31:0] value, bit typed, t_result want);
        int gap;
        int base;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= value;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        base = pending_results.size();
        queue_predict(op, value);
        // A hand-written expectation takes the place of the computed one.
        if (typed) begin
            while (pending_results.size() > base) void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        items_sent++;
        if (op != OP_IGNORED) counted_items++;
    endtask

    task automatic send_random(logic [1:0] op);
        send_item(op, pick_value(), 1'b0, make_result(ST_OK, '0, '0, 1'b0));
    endtask

    function automatic void report(string field, logic [31:0] want, logic [31:0] got);
        error_count++;
        $display("%0t: mismatch on %s: expected %h, actual %h", $time, field, want, got);
    endfunction

    // Compare every master-side transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report("unexpected result item", '0, o_m_tdata[31:0]);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_m_tuser !== want.status)
                    report("status", 32'(want.status), 32'(o_m_tuser));
                if (o_m_tdata[31:0] !== want.item)
                    report("item", want.item, o_m_tdata[31:0]);
                if (o_m_tdata[37:32] !== want.held)
                    report("entries_held", 32'(want.held), 32'(o_m_tdata[37:32]));
                if (o_m_tdata[39:38] !== 2'b00)
                    report("padding", 32'd0, 32'(o_m_tdata[39:38]));
                if (o_m_tlast !== want.last)
                    report("last", 32'(want.last), 32'(o_m_tlast));
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((i_s_tvalid && o_s_tready === 1'b1) || (o_m_tvalid === 1'b1 && i_m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, pending_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: runs of ready with stalls of random length.
    initial begin
        int run;
        int stall;
        int r;
        i_m_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        forever begin
            if (draining) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 6);
                i_m_tready <= 1'b1;
                repeat (run) @(posedge i_clk);
                r = $urandom_range(0, 99);
                if (r < 45)      stall = 0;
                else if (r < 92) stall = $urandom_range(1, 3);
                else             stall = $urandom_range(10, 40);
                if (stall > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        int n;
        int r;
        error_count     = 0;
        items_sent      = 0;
        counted_items   = 0;
        results_checked = 0;
        full_results    = 0;
        empty_results   = 0;
        quiet           = 1'b0;
        draining        = 1'b0;
        shadow_head     = 0;
        shadow_tail     = 0;
        shadow_count    = 0;
        idle_cycles     = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: empty cases, extremes, every code and the ignored one.
        add_row(OP_DEQ,     32'h0000_0000, 1, ST_EMPTY, '0, 6'd0);
        add_row(OP_SHOW,    32'h0000_0000, 1, ST_EMPTY, '0, 6'd0);
        add_row(OP_IGNORED, 32'hFFFF_FFFF, 0, ST_OK,    '0, 6'd0);
        add_row(OP_ENQ,     32'h8000_0000, 1, ST_OK,    '0, 6'd1);
        add_row(OP_ENQ,     32'h7FFF_FFFF, 1, ST_OK,    '0, 6'd2);
        add_row(OP_ENQ,     32'h0000_0000, 1, ST_OK,    '0, 6'd3);
        add_row(OP_ENQ,     32'hFFFF_FFFF, 1, ST_OK,    '0, 6'd4);
        add_row(OP_ENQ,     32'h0000_0001, 1, ST_OK,    '0, 6'd5);
        add_row(OP_SHOW,    32'h0000_0000, 0, ST_OK,    '0, 6'd0);
        add_row(OP_DEQ,     32'h0000_0000, 1, ST_OK,    32'h8000_0000, 6'd4);
        add_row(OP_DEQ,     32'hFFFF_FFFF, 1, ST_OK,    32'h7FFF_FFFF, 6'd3);
        add_row(OP_IGNORED, 32'h1234_5678, 0, ST_OK,    '0, 6'd0);
        add_row(OP_SHOW,    32'hFFFF_FFFF, 0, ST_OK,    '0, 6'd0);
        add_row(OP_DEQ,     32'h0000_0000, 0, ST_OK,    '0, 6'd0);
        add_row(OP_DEQ,     32'h0000_0000, 0, ST_OK,    '0, 6'd0);
        add_row(OP_DEQ,     32'h0000_0000, 0, ST_OK,    '0, 6'd0);
        add_row(OP_DEQ,     32'h0000_0000, 1, ST_EMPTY, '0, 6'd0);
        add_row(OP_SHOW,    32'h0000_0000, 1, ST_EMPTY, '0, 6'd0);
        add_row(OP_ENQ,     32'hA5A5_A5A5, 1, ST_OK,    '0, 6'd1);
        add_row(OP_SHOW,    32'h0000_0000, 1, ST_OK,    32'hA5A5_A5A5, 6'd1);
        add_row(OP_DEQ,     32'hDEAD_BEEF, 1, ST_OK,    32'hA5A5_A5A5, 6'd0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].want);
        counted_items = 0;

        // Random phases: fill to full or past it, drain to empty or past it, or a free mix.
        while (counted_items < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0: begin
                    n = DEPTH - shadow_count + $urandom_range(0, 2);
                    repeat (n) send_random(OP_ENQ);
                    if ($urandom_range(0, 1) == 1) send_random(OP_SHOW);
                end
                1: begin
                    n = shadow_count + $urandom_range(0, 2);
                    repeat (n) send_random(OP_DEQ);
                    if ($urandom_range(0, 1) == 1) send_random(OP_SHOW);
                end
                default: begin
                    repeat ($urandom_range(8, 24)) begin
                        r = $urandom_range(0, 99);
                        if (r < 42)      send_random(OP_ENQ);
                        else if (r < 78) send_random(OP_DEQ);
                        else if (r < 93) send_random(OP_SHOW);
                        else             send_random(OP_IGNORED);
                    end
                end
            endcase
        end
        i_s_tvalid <= 1'b0;

        // Drain: let every expected result arrive, then watch for strays.
        draining = 1'b1;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Sent %0d commands, checked %0d results (%0d full, %0d empty).",
                 items_sent, results_checked, full_results, empty_results);
        $display("Queue filled past capacity and drained past empty under random stalls.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fqw_pkg.sv
hw/rtl/fqw_ram.sv
hw/rtl/fqw_front.sv
hw/rtl/fqw_back.sv
hw/rtl/fifo_queue_with_walk_core.sv
tb/sv/testbench.sv
